// ===== rtl/gga_pkg.sv =====
// ----------------------------------------------------------------------------
// gga_pkg
// Shared types and constants of the gapped global alignment core.
// ----------------------------------------------------------------------------
package gga_pkg;

   localparam logic [14:0] FULL_SCORE = 15'd25600;

   typedef enum logic [1:0] {
      STEP_PAIR = 2'd0,
      STEP_ROW  = 2'd1,
      STEP_COL  = 2'd2
   } step_type;

   typedef enum logic [2:0] {
      CSR_ROW_COUNT  = 3'd0,
      CSR_COL_COUNT  = 3'd1,
      CSR_ROW_OFFSET = 3'd2,
      CSR_COL_OFFSET = 3'd3,
      CSR_THRESHOLD  = 3'd4,
      CSR_GAP_COST   = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_ROW,
      ST_FILL_RD,
      ST_FILL_CALC,
      ST_TB_RD,
      ST_TB_USE,
      ST_EM_RD,
      ST_EM_OUT
   } state_type;

endpackage

// ===== rtl/gga_ram.sv =====
// ----------------------------------------------------------------------------
// gga_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module gga_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                        wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                        rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/gga_cell.sv =====
// ----------------------------------------------------------------------------
// gga_cell
// Shared add and compare unit: picks the cheapest step into one cell; a pair step needs score >= threshold.
// ----------------------------------------------------------------------------
module gga_cell import gga_pkg::*; #(
   parameter int CSW = 21
) (
   input  logic [CSW-1:0] diag_cost,
   input  logic [CSW-1:0] up_cost,
   input  logic [CSW-1:0] left_cost,
   input  logic [14:0]    score,
   input  logic [14:0]    threshold,
   input  logic [14:0]    gap,
   output step_type       code,
   output logic [CSW-1:0] best
);

   logic [CSW-1:0] up_sum;
   logic [CSW-1:0] left_sum;
   logic [CSW-1:0] diag_sum;

   always_comb begin
      up_sum   = up_cost + CSW'(gap);
      left_sum = left_cost + CSW'(gap);
      diag_sum = diag_cost + CSW'(FULL_SCORE - score);
      if (score >= threshold && diag_sum <= up_sum && diag_sum <= left_sum) begin
         code = STEP_PAIR;
         best = diag_sum;
      end else if (up_sum <= left_sum) begin
         code = STEP_ROW;
         best = up_sum;
      end else begin
         code = STEP_COL;
         best = left_sum;
      end
   end

endmodule

// ===== rtl/gapped_global_alignment_dp_core.sv =====
// ----------------------------------------------------------------------------
// gapped_global_alignment_dp_core
// Global alignment of a scored row by column matrix with linear gap cost.
// ----------------------------------------------------------------------------
// Usage: the csr_ port sets the counts, offsets, threshold and gap cost; the
// user must write it only while the core is idle, which the core does not
// enforce. An item is taken when start is high and busy is low. A load item
// (opcode 0) writes the next similarity score in row-major order and leaves
// busy low. A start item (opcode 1) raises busy and runs the alignment: it
// seeds the first cost row, fills each matrix cell row by row through the
// shared add and compare unit (the cost row RAM is read and written once per
// cell), traces the path back from the last cell and emits the results.
// Results leave in forward order, each marked by rsp_strobe for one cycle;
// busy stays high until the last, and the receiver cannot stall, so nothing
// waits. rsp_final_res marks the last one. A matrix with no rows and no
// columns gives no result. Reset clears the state machine, the configuration
// registers, the load pointer and rsp_strobe; the RAMs need no clearing pass.
// ----------------------------------------------------------------------------
module gapped_global_alignment_dp_core import gga_pkg::*; #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_opcode,
   input  logic [14:0] req_similarity,
   output logic        rsp_strobe,
   output logic        rsp_row_present,
   output logic [15:0] rsp_row_index,
   output logic        rsp_col_present,
   output logic [15:0] rsp_col_index,
   output logic [14:0] rsp_pair_score,
   output logic        rsp_final_res,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int RW   = $clog2(MAX_ROWS + 1);
   localparam int CW   = $clog2(MAX_COLS + 1);
   localparam int SD   = MAX_ROWS * MAX_COLS;
   localparam int SAW  = (SD > 1) ? $clog2(SD) : 1;
   localparam int LPW  = $clog2(SD + 1);
   localparam int TD   = (MAX_ROWS + 1) * (MAX_COLS + 1);
   localparam int TAW  = $clog2(TD);
   localparam int CD   = MAX_COLS;
   localparam int CAW  = (CD > 1) ? $clog2(CD) : 1;
   localparam int PD   = MAX_ROWS + MAX_COLS;
   localparam int PAW  = $clog2(PD);
   localparam int LW   = $clog2(PD + 1);
   localparam int PW   = 15 + CW + RW + 2;
   localparam int CSW  = $clog2((MAX_ROWS + MAX_COLS + 2) * 32768);
   localparam logic [8:0]     MR9      = 9'(MAX_ROWS);
   localparam logic [8:0]     MC9      = 9'(MAX_COLS);
   localparam logic [TAW-1:0] ROW_STEP = TAW'(MAX_COLS + 1);
   localparam logic [TAW-1:0] DIA_STEP = TAW'(MAX_COLS + 2);
   localparam logic [LPW-1:0] SD_LIM   = LPW'(SD);

   // configuration registers
   logic [5:0]  row_count_ff, col_count_ff;
   logic [15:0] row_offset_ff, col_offset_ff;
   logic [14:0] threshold_ff, gap_ff;

   state_type state_ff, state_in;
   logic [RW-1:0]  n_ff, n_in, i_ff, i_in;
   logic [CW-1:0]  m_ff, m_in, j_ff, j_in;
   logic [SAW-1:0] sa_ff, sa_in;
   logic [TAW-1:0] ta_ff, ta_in, rb_ff, rb_in;
   logic [CSW-1:0] c0_ff, c0_in, diag_ff, diag_in, left_ff, left_in;
   logic [LW-1:0]  len_ff, len_in;
   logic [LPW-1:0] lp_ff, lp_in;

   logic        rsp_strobe_ff, rsp_final_ff;
   logic        rsp_row_p_ff, rsp_col_p_ff;
   logic [15:0] rsp_row_ix_ff, rsp_col_ix_ff;
   logic [14:0] rsp_score_ff;

   logic [8:0]    n9, m9;
   logic          accept_load, accept_start;
   logic [14:0]   load_score;
   logic [14:0]   score_rd;
   logic [CSW-1:0] cost_rd;
   logic [1:0]    trace_rd;
   logic [PW-1:0] path_rd, path_wd;
   step_type      cell_code, tb_code, em_code;
   logic [CSW-1:0] cell_best;
   logic [CSW-1:0] cost_wd;
   logic [RW-1:0] em_ri;
   logic [CW-1:0] em_ci;
   logic [14:0]   em_score;
   logic [RW-1:0] tb_ri;
   logic [CW-1:0] tb_ci;

   assign busy         = (state_ff != ST_IDLE);
   assign accept_load  = start && !busy && !req_opcode;
   assign accept_start = start && !busy && req_opcode;
   assign load_score   = (req_similarity > FULL_SCORE) ? FULL_SCORE : req_similarity;

   always_comb begin
      n9 = (9'(row_count_ff) > MR9) ? MR9 : 9'(row_count_ff);
      m9 = (9'(col_count_ff) > MC9) ? MC9 : 9'(col_count_ff);
   end

   // Configuration port
   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff  <= '0;
         col_count_ff  <= '0;
         row_offset_ff <= '0;
         col_offset_ff <= '0;
         threshold_ff  <= '0;
         gap_ff        <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROW_COUNT:  row_count_ff  <= csr_wdata[5:0];
            CSR_COL_COUNT:  col_count_ff  <= csr_wdata[5:0];
            CSR_ROW_OFFSET: row_offset_ff <= csr_wdata;
            CSR_COL_OFFSET: col_offset_ff <= csr_wdata;
            CSR_THRESHOLD:  threshold_ff  <= csr_wdata[14:0];
            CSR_GAP_COST:   gap_ff        <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   gga_cell #(.CSW(CSW)) u_cell (
      .diag_cost (diag_ff),
      .up_cost   (cost_rd),
      .left_cost (left_ff),
      .score     (score_rd),
      .threshold (threshold_ff),
      .gap       (gap_ff),
      .code      (cell_code),
      .best      (cell_best)
   );

   gga_ram #(.WIDTH(15), .DEPTH(SD)) u_score_ram (
      .clock (clock),
      .we    (accept_load && (lp_ff < SD_LIM)),
      .waddr (lp_ff[SAW-1:0]),
      .wdata (load_score),
      .raddr (sa_ff),
      .rdata (score_rd)
   );

   assign cost_wd = (state_ff == ST_INIT) ? (left_ff + CSW'(gap_ff)) : cell_best;

   gga_ram #(.WIDTH(CSW), .DEPTH(CD)) u_cost_ram (
      .clock (clock),
      .we    ((state_ff == ST_INIT) || (state_ff == ST_FILL_CALC)),
      .waddr (CAW'(j_ff - 1'b1)),
      .wdata (cost_wd),
      .raddr (CAW'(j_ff - 1'b1)),
      .rdata (cost_rd)
   );

   gga_ram #(.WIDTH(2), .DEPTH(TD)) u_trace_ram (
      .clock (clock),
      .we    (state_ff == ST_FILL_CALC),
      .waddr (rb_ff + TAW'(j_ff)),
      .wdata (cell_code),
      .raddr (ta_ff),
      .rdata (trace_rd)
   );

   // Traceback step decode; border cells have a fixed direction.
   always_comb begin
      if (i_ff == '0) begin
         tb_code = STEP_COL;
      end else if (j_ff == '0) begin
         tb_code = STEP_ROW;
      end else if (trace_rd == STEP_PAIR) begin
         tb_code = STEP_PAIR;
      end else if (trace_rd == STEP_ROW) begin
         tb_code = STEP_ROW;
      end else begin
         tb_code = STEP_COL;
      end
      tb_ri   = (i_ff != '0) ? i_ff - 1'b1 : '0;
      tb_ci   = (j_ff != '0) ? j_ff - 1'b1 : '0;
      path_wd = {((tb_code == STEP_PAIR) ? score_rd : 15'd0), tb_ci, tb_ri, tb_code};
   end

   gga_ram #(.WIDTH(PW), .DEPTH(PD)) u_path_ram (
      .clock (clock),
      .we    (state_ff == ST_TB_USE),
      .waddr (len_ff[PAW-1:0]),
      .wdata (path_wd),
      .raddr (PAW'(len_ff - 1'b1)),
      .rdata (path_rd)
   );

   always_comb begin
      em_code  = step_type'(path_rd[1:0]);
      em_ri    = path_rd[RW+1:2];
      em_ci    = path_rd[CW+RW+1:RW+2];
      em_score = path_rd[PW-1:CW+RW+2];
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_start) begin
               state_in = (m9 != 9'd0) ? ST_INIT : ST_ROW;
            end
         end
         ST_INIT: begin
            if (j_ff == m_ff) state_in = ST_ROW;
         end
         ST_ROW: begin
            if (i_ff == n_ff) state_in = ST_TB_RD;
            else if (m_ff != '0) state_in = ST_FILL_RD;
         end
         ST_FILL_RD:   state_in = ST_FILL_CALC;
         ST_FILL_CALC: state_in = (j_ff == m_ff) ? ST_ROW : ST_FILL_RD;
         ST_TB_RD: begin
            if (i_ff == '0 && j_ff == '0) begin
               state_in = (len_ff == '0) ? ST_IDLE : ST_EM_RD;
            end else begin
               state_in = ST_TB_USE;
            end
         end
         ST_TB_USE: state_in = ST_TB_RD;
         ST_EM_RD:  state_in = ST_EM_OUT;
         ST_EM_OUT: state_in = (len_ff == LW'(1)) ? ST_IDLE : ST_EM_RD;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Datapath registers
   always_comb begin
      n_in    = n_ff;
      m_in    = m_ff;
      i_in    = i_ff;
      j_in    = j_ff;
      sa_in   = sa_ff;
      ta_in   = ta_ff;
      rb_in   = rb_ff;
      c0_in   = c0_ff;
      diag_in = diag_ff;
      left_in = left_ff;
      len_in  = len_ff;
      lp_in   = lp_ff;
      if (accept_load && (lp_ff < SD_LIM)) lp_in = lp_ff + 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept_start) begin
               n_in    = n9[RW-1:0];
               m_in    = m9[CW-1:0];
               i_in    = '0;
               j_in    = CW'(1);
               sa_in   = '0;
               rb_in   = '0;
               c0_in   = '0;
               left_in = '0;
               len_in  = '0;
               lp_in   = '0;
            end
         end
         ST_INIT: begin
            left_in = cost_wd;
            j_in    = j_ff + 1'b1;
         end
         ST_ROW: begin
            if (i_ff == n_ff) begin
               j_in  = m_ff;
               ta_in = rb_ff + TAW'(m_ff);
               sa_in = sa_ff - 1'b1;
            end else begin
               i_in    = i_ff + 1'b1;
               rb_in   = rb_ff + ROW_STEP;
               diag_in = c0_ff;
               c0_in   = c0_ff + CSW'(gap_ff);
               left_in = c0_ff + CSW'(gap_ff);
               j_in    = CW'(1);
            end
         end
         ST_FILL_CALC: begin
            diag_in = cost_rd;
            left_in = cell_best;
            sa_in   = sa_ff + 1'b1;
            j_in    = j_ff + 1'b1;
         end
         ST_TB_USE: begin
            len_in = len_ff + 1'b1;
            unique case (tb_code)
               STEP_PAIR: begin
                  i_in  = i_ff - 1'b1;
                  j_in  = j_ff - 1'b1;
                  ta_in = ta_ff - DIA_STEP;
                  sa_in = sa_ff - SAW'(m_ff) - 1'b1;
               end
               STEP_ROW: begin
                  i_in  = i_ff - 1'b1;
                  ta_in = ta_ff - ROW_STEP;
                  sa_in = sa_ff - SAW'(m_ff);
               end
               default: begin
                  j_in  = j_ff - 1'b1;
                  ta_in = ta_ff - 1'b1;
                  sa_in = sa_ff - 1'b1;
               end
            endcase
         end
         ST_EM_OUT: len_in = len_ff - 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         lp_ff         <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         lp_ff         <= lp_in;
         rsp_strobe_ff <= (state_ff == ST_EM_OUT);
      end
   end

   always_ff @(posedge clock) begin
      n_ff    <= n_in;
      m_ff    <= m_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      sa_ff   <= sa_in;
      ta_ff   <= ta_in;
      rb_ff   <= rb_in;
      c0_ff   <= c0_in;
      diag_ff <= diag_in;
      left_ff <= left_in;
      len_ff  <= len_in;
      if (state_ff == ST_EM_OUT) begin
         rsp_row_p_ff  <= (em_code != STEP_COL);
         rsp_col_p_ff  <= (em_code != STEP_ROW);
         rsp_row_ix_ff <= (em_code != STEP_COL) ? row_offset_ff + 16'(em_ri) : 16'd0;
         rsp_col_ix_ff <= (em_code != STEP_ROW) ? col_offset_ff + 16'(em_ci) : 16'd0;
         rsp_score_ff  <= (em_code == STEP_PAIR) ? em_score : 15'd0;
         rsp_final_ff  <= (len_ff == LW'(1));
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_row_present = rsp_row_p_ff;
   assign rsp_row_index   = rsp_row_ix_ff;
   assign rsp_col_present = rsp_col_p_ff;
   assign rsp_col_index   = rsp_col_ix_ff;
   assign rsp_pair_score  = rsp_score_ff;
   assign rsp_final_res   = rsp_final_ff;

endmodule
